// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every edge outside reset.
`define ACGE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every edge, reset included.
`define ACGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/acge_pkg.sv =====
// Package: types and constants of the gateway engine.
`timescale 1ns / 1ps
package acge_pkg;
	localparam logic [7:0] GW_PORT      = 8'hd2;
	localparam logic [7:0] CTRL_REQUEST = 8'ha1;
	localparam logic [7:0] CTRL_REPLY   = 8'ha2;
	localparam logic [7:0] CTRL_DATA    = 8'h81;
	localparam logic [15:0] NET_BITS   = 16'hff00;
	localparam logic [7:0] QUERY_ADDR   = 8'hff;

	localparam logic [2:0] V_IGNORE = 3'd0;
	localparam logic [2:0] V_REPLY  = 3'd1;
	localparam logic [2:0] V_TUNNEL = 3'd2;
	localparam logic [2:0] V_SEND   = 3'd3;
	localparam logic [2:0] V_QUERY  = 3'd4;
	localparam logic [2:0] V_DROP   = 3'd5;
	localparam logic [2:0] V_BUSY   = 3'd6;

	localparam logic [1:0] ACT_FRAME   = 2'd0;
	localparam logic [1:0] ACT_TUNNEL  = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	localparam logic [1:0] CFG_LOCAL_IP   = 2'd0;
	localparam logic [1:0] CFG_PREFIX_LEN = 2'd1;
	localparam logic [1:0] CFG_BCAST_TYPE = 2'd2;
	localparam logic [1:0] CFG_DATA_TYPE  = 2'd3;

	// Classified event handed from the front to the back.
	typedef struct packed {
		logic [1:0]  action;
		logic        is_req;
		logic        is_tun;
		logic        is_rep;
		logic        in_sub;
		logic [15:0] station;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] rip;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [7:0]  net;
		logic [7:0]  stn;
		logic [31:0] first_ip;
		logic [31:0] second_ip;
	} res_t;
endpackage

// ===== rtl/acge_intf.sv =====
// Interfaces: event input, verdict output and configuration write channels.
`timescale 1ns / 1ps
interface gw_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  frame_type;
	logic [7:0]  frame_port;
	logic [7:0]  frame_ctrl;
	logic [7:0]  source_net;
	logic [7:0]  source_station;
	logic [31:0] first_word_ip;
	logic [31:0] second_word_ip;
	logic [31:0] route_ip;
	modport source (output valid, action, frame_type, frame_port, frame_ctrl, source_net,
		source_station, first_word_ip, second_word_ip, route_ip, input ready);
	modport sink (input valid, action, frame_type, frame_port, frame_ctrl, source_net,
		source_station, first_word_ip, second_word_ip, route_ip, output ready);
endinterface

interface gw_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  target_net;
	logic [7:0]  target_station;
	logic [31:0] out_first_ip;
	logic [31:0] out_second_ip;
	modport source (output valid, verdict, target_net, target_station, out_first_ip,
		out_second_ip, input ready);
	modport sink (input valid, verdict, target_net, target_station, out_first_ip,
		out_second_ip, output ready);
endinterface

interface gw_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/arp_cache_gateway_engine_unit.sv =====
// Top level: gateway engine with an address-resolution cache.
// The back end takes one event at a time; events that use the cache are paced by the
// cache walk, which reads one entry a cycle, and a send on a hit also reads the station.
// Reset (arst_n low, asynchronous): all cache entries invalid, no pending query,
// registers at local_ip 0, prefix 24, broadcast type 1, data type 2.
`timescale 1ns / 1ps
module arp_cache_gateway_engine_unit #(
	parameter int CACHE_DEPTH  = 16,
	parameter int MAX_ATTEMPTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	gw_in_if.sink    req,
	gw_out_if.source rsp,
	gw_cfg_if.sink   cfg
);
	import acge_pkg::*;

	// Configuration registers; the user must write them only while the engine is idle, as the block does not enforce it.
	logic [31:0] local_ip_q;
	logic [5:0]  prefix_len_q;
	logic [7:0]  bcast_type_q;
	logic [7:0]  data_type_q;

	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	// The configuration channel never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q   <= 32'd0;
			prefix_len_q <= 6'd24;
			bcast_type_q <= 8'd1;
			data_type_q  <= 8'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LOCAL_IP:   local_ip_q   <= cfg.data;
				CFG_PREFIX_LEN: prefix_len_q <= cfg.data[5:0];
				CFG_BCAST_TYPE: bcast_type_q <= cfg.data[7:0];
				CFG_DATA_TYPE:  data_type_q  <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Front: take a beat, classify headers, hand a command to the queue.
	acge_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.local_ip        (local_ip_q),
		.prefix_len      (prefix_len_q),
		.bcast_type_code (bcast_type_q),
		.data_type_code  (data_type_q),
		.push_valid      (push_valid),
		.push_data       (push_data),
		.push_ready      (push_ready)
	);

	// Queue: lets the front keep taking beats while the back walks the cache.
	acge_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	// Back: walk the cache, learn entries, track the pending query, drive verdicts.
	acge_back #(
		.CACHE_DEPTH  (CACHE_DEPTH),
		.MAX_ATTEMPTS (MAX_ATTEMPTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.local_ip  (local_ip_q),
		.rsp       (rsp)
	);
endmodule

// ===== rtl/acge_front.sv =====
// Front end: accept events and classify their headers into commands.
`timescale 1ns / 1ps
module acge_front (
	input  logic               clk,
	input  logic               arst_n,
	gw_in_if.sink              req,
	input  logic [31:0]        local_ip,
	input  logic [5:0]         prefix_len,
	input  logic [7:0]         bcast_type_code,
	input  logic [7:0]         data_type_code,
	output logic               push_valid,
	output acge_pkg::cmd_t     push_data,
	input  logic               push_ready
);
	import acge_pkg::*;

	logic        v_s1;
	cmd_t        cmd_s1;
	cmd_t        cmd_d;
	logic [5:0]  plen;
	logic [31:0] mask;
	logic        take;

	always_comb begin
		plen = (prefix_len > 6'd32) ? 6'd32 : prefix_len;
		mask = (plen == 6'd0) ? 32'h0 : (32'hffff_ffff << (6'd32 - plen));
		cmd_d.action  = req.action;
		cmd_d.is_req  = (req.frame_type == bcast_type_code) && (req.frame_port == GW_PORT) &&
			(req.frame_ctrl == CTRL_REQUEST) && (req.second_word_ip == local_ip);
		cmd_d.is_tun  = (req.frame_type == data_type_code) && (req.frame_port == GW_PORT) &&
			(req.frame_ctrl == CTRL_DATA);
		cmd_d.is_rep  = (req.frame_type == data_type_code) && (req.frame_port == GW_PORT) &&
			(req.frame_ctrl == CTRL_REPLY) && (req.second_word_ip == local_ip);
		cmd_d.in_sub  = (req.route_ip & mask) == (local_ip & mask);
		cmd_d.station = {req.source_net, req.source_station};
		cmd_d.w0      = req.first_word_ip;
		cmd_d.w1      = req.second_word_ip;
		cmd_d.rip     = req.route_ip;
	end

	assign req.ready  = !v_s1 || push_ready;
	assign take       = req.valid && req.ready;
	assign push_valid = v_s1;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end
endmodule

// ===== rtl/acge_queue.sv =====
// Two-entry command queue between the front and the back.
`timescale 1ns / 1ps
module acge_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  acge_pkg::cmd_t push_data,
	output logic           push_ready,
	output logic           pop_valid,
	output acge_pkg::cmd_t pop_data,
	input  logic           pop_ready
);
	import acge_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = slot_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end
endmodule

// ===== rtl/acge_back.sv =====
// Back end: cache walk, learning, pending query tracking and verdict output.
`timescale 1ns / 1ps
module acge_back #(
	parameter int CACHE_DEPTH  = 16,
	parameter int MAX_ATTEMPTS = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	input  acge_pkg::cmd_t pop_data,
	output logic           pop_ready,
	input  logic [31:0]    local_ip,
	gw_out_if.source       rsp
);
	import acge_pkg::*;

	localparam int AW    = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_DONE = 3'd2;
	localparam logic [2:0] ST_STRD = 3'd3;
	localparam logic [2:0] ST_STWT = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [31:0] ip_mem [CACHE_DEPTH];
	logic [15:0] st_mem [CACHE_DEPTH];

	logic [2:0]       state_q;
	logic             learn_q;
	logic [31:0]      key_q;
	logic [15:0]      stn_q;
	logic             pend_q;
	logic [31:0]      pip_q;
	logic [2:0]       att_q;
	logic [AW-1:0]    rptr_q;
	logic [CACHE_DEPTH-1:0] vld_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;
	logic [31:0]      ip_rd_s1;
	logic             hit_q;
	logic [AW-1:0]    hit_idx_q;
	logic             free_q;
	logic [AW-1:0]    free_idx_q;
	logic [15:0]      st_rd_q;
	res_t             res_q;
	res_t             out_q;
	logic             out_v_q;

	logic             issue;
	logic             we;
	logic [AW-1:0]    widx;
	logic             load_out;
	cmd_t             c;

	res_t             dec_res;
	logic             dec_learn;
	logic             dec_walk;
	logic             dec_clr_pend;
	logic             dec_bump;
	logic [31:0]      dec_key;

	assign c         = pop_data;
	assign pop_ready = state_q == ST_IDLE;
	assign issue     = (state_q == ST_WALK) && (cnt_q != CNT_W'(CACHE_DEPTH));
	assign we        = (state_q == ST_DONE) && learn_q;
	assign widx      = hit_q ? hit_idx_q : (free_q ? free_idx_q : rptr_q);
	assign load_out  = (state_q == ST_EMIT) && (!out_v_q || rsp.ready);

	assign rsp.valid          = out_v_q;
	assign rsp.verdict        = out_q.verdict;
	assign rsp.target_net     = out_q.net;
	assign rsp.target_station = out_q.stn;
	assign rsp.out_first_ip   = out_q.first_ip;
	assign rsp.out_second_ip  = out_q.second_ip;

	// Decode the command at the head of the queue.
	always_comb begin
		dec_res      = '0;
		dec_learn    = 1'b0;
		dec_walk     = 1'b0;
		dec_clr_pend = 1'b0;
		dec_bump     = 1'b0;
		dec_key      = c.rip;
		if (pend_q) begin
			if (c.action == ACT_TUNNEL) begin
				dec_res.verdict = V_BUSY;
			end else if (c.action == ACT_FRAME && c.is_rep && c.w0 == pip_q) begin
				// matching reply: learn it, then send
				dec_learn    = 1'b1;
				dec_walk     = 1'b1;
				dec_clr_pend = 1'b1;
				dec_key      = pip_q;
				dec_res      = '{V_SEND, c.station[15:8], c.station[7:0], 32'h0, 32'h0};
			end else if (c.action == ACT_FRAME || c.action == ACT_TIMEOUT) begin
				if (att_q < 3'(MAX_ATTEMPTS)) begin
					dec_bump = 1'b1;
					dec_res  = '{V_QUERY, QUERY_ADDR, QUERY_ADDR, local_ip, pip_q};
				end else begin
					dec_clr_pend    = 1'b1;
					dec_res.verdict = V_DROP;
				end
			end
		end else if (c.action == ACT_FRAME) begin
			if (c.is_req) begin
				dec_learn = 1'b1;
				dec_walk  = 1'b1;
				dec_key   = c.w0;
				dec_res   = '{V_REPLY, c.station[15:8], c.station[7:0], c.w1, c.w0};
			end else if (c.is_tun) begin
				dec_res.verdict = V_TUNNEL;
			end
		end else if (c.action == ACT_TUNNEL) begin
			if (!c.in_sub) begin
				dec_res.verdict = V_DROP;
			end else begin
				dec_walk = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ip_rd_s1 <= ip_mem[cnt_q[AW-1:0]];
		end
		if (state_q == ST_STRD) begin
			st_rd_q <= st_mem[hit_idx_q];
		end
		if (we) begin
			ip_mem[widx] <= key_q;
			st_mem[widx] <= stn_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			learn_q    <= 1'b0;
			key_q      <= '0;
			stn_q      <= '0;
			pend_q     <= 1'b0;
			pip_q      <= '0;
			att_q      <= '0;
			rptr_q     <= '0;
			vld_q      <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			res_q      <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						res_q   <= dec_res;
						learn_q <= dec_learn;
						key_q   <= dec_key;
						stn_q   <= c.station;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= dec_walk ? ST_WALK : ST_EMIT;
						if (dec_clr_pend) begin
							pend_q <= 1'b0;
							att_q  <= '0;
						end else if (dec_bump) begin
							att_q <= att_q + 3'd1;
						end
					end
				end
				ST_WALK: begin
					// issue one read a cycle, compare it the cycle after
					rd_vld_s1 <= issue;
					if (issue) begin
						rd_idx_s1 <= cnt_q[AW-1:0];
						cnt_q     <= cnt_q + CNT_W'(1);
					end
					if (rd_vld_s1) begin
						if (vld_q[rd_idx_s1] && ip_rd_s1 == key_q && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= rd_idx_s1;
						end
						if (!vld_q[rd_idx_s1] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
					end
					if (!issue && !rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (learn_q) begin
						vld_q[widx] <= 1'b1;
						if (!hit_q && !free_q) begin
							rptr_q <= (rptr_q == AW'(CACHE_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
						end
						state_q <= ST_EMIT;
					end else if (hit_q) begin
						state_q <= ST_STRD;
					end else begin
						pend_q  <= 1'b1;
						pip_q   <= key_q;
						att_q   <= 3'd1;
						res_q   <= '{V_QUERY, QUERY_ADDR, QUERY_ADDR, local_ip, key_q};
						state_q <= ST_EMIT;
					end
				end
				ST_STRD: begin
					state_q <= ST_STWT;
				end
				ST_STWT: begin
					res_q   <= '{V_SEND, st_rd_q[15:8], st_rd_q[7:0], 32'h0, 32'h0};
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== rtl/acge_checker.sv =====
// Checker on the top level's output ports, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acge_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  verdict,
	input logic [7:0]  target_net,
	input logic [7:0]  target_station,
	input logic [31:0] out_first_ip,
	input logic [31:0] out_second_ip
);
	import acge_pkg::*;

	`ACGE_ASSERT_ALWAYS(a_no_beat_in_reset, clk, !arst_n |-> !out_valid, "beat during reset")
	`ACGE_ASSERT(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "beat dropped")
	`ACGE_ASSERT(a_code, clk, arst_n, out_valid |-> verdict <= V_BUSY, "bad verdict code")
	`ACGE_ASSERT(a_query_bcast, clk, arst_n, out_valid && verdict == V_QUERY |-> target_net == QUERY_ADDR && target_station == QUERY_ADDR, "query not broadcast")
	`ACGE_ASSERT(a_plain_zero, clk, arst_n, out_valid && (verdict == V_TUNNEL || verdict == V_DROP || verdict == V_BUSY) |-> target_net == 8'd0 && out_first_ip == 32'd0 && out_second_ip == 32'd0, "stray fields")
endmodule

bind arp_cache_gateway_engine_unit acge_checker u_acge_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.verdict        (rsp.verdict),
	.target_net     (rsp.target_net),
	.target_station (rsp.target_station),
	.out_first_ip   (rsp.out_first_ip),
	.out_second_ip  (rsp.out_second_ip)
);

// ===== tb/gw_tb_types.sv =====
// Shared testbench types: one event beat and one verdict beat.
`timescale 1ns / 1ps
package gw_tb_types;
	import acge_pkg::*;

	typedef struct {
		logic [1:0]  action;
		logic [7:0]  ftype;
		logic [7:0]  port;
		logic [7:0]  ctrl;
		logic [7:0]  snet;
		logic [7:0]  sstn;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] rip;
	} gw_event_t;

	typedef struct {
		logic [2:0]  verdict;
		logic [7:0]  net;
		logic [7:0]  stn;
		logic [31:0] first_ip;
		logic [31:0] second_ip;
	} gw_verdict_t;
endpackage

// ===== tb/gw_verdict_checker.sv =====
// Checker: mirrors the gateway's cache state and compares every verdict beat.
`timescale 1ns / 1ps
module gw_verdict_checker #(
	parameter int CACHE_DEPTH  = 16,
	parameter int MAX_ATTEMPTS = 5
) (
	input  logic clk,
	input  logic arst_n,
	gw_in_if     req,
	gw_out_if    rsp,
	gw_cfg_if    cfg,
	output int   errors,
	output int   pending_verdicts
);
	import acge_pkg::*;
	import gw_tb_types::*;

	logic [31:0] local_ip;
	logic [5:0]  prefix_len;
	logic [7:0]  bcast_type, data_type;
	logic [31:0] cache_ip [CACHE_DEPTH];
	logic [15:0] cache_stn [CACHE_DEPTH];
	logic        cache_ok [CACHE_DEPTH];
	int          repl_ptr;
	logic        waiting;
	logic [31:0] wait_ip;
	int          tries;
	gw_verdict_t verdict_q[$];

	assign pending_verdicts = verdict_q.size();

	function automatic int lookup(logic [31:0] ip);
		for (int i = 0; i < CACHE_DEPTH; i++)
			if (cache_ok[i] && cache_ip[i] == ip) return i;
		return -1;
	endfunction

	function automatic void learn(logic [31:0] ip, logic [15:0] stn);
		int i;
		i = lookup(ip);
		if (i < 0) begin
			for (i = 0; i < CACHE_DEPTH; i++)
				if (!cache_ok[i]) break;
			if (i == CACHE_DEPTH) begin
				i = repl_ptr;
				repl_ptr = (repl_ptr + 1) % CACHE_DEPTH;
			end
			cache_ip[i] = ip;
			cache_ok[i] = 1'b1;
		end
		cache_stn[i] = stn;
	endfunction

	function automatic gw_verdict_t make(logic [2:0] v, logic [7:0] n, logic [7:0] s,
			logic [31:0] a, logic [31:0] b);
		gw_verdict_t r;
		r.verdict = v; r.net = n; r.stn = s; r.first_ip = a; r.second_ip = b;
		return r;
	endfunction

	function automatic gw_verdict_t predict_verdict(gw_event_t e);
		logic [31:0] mask;
		int p, i;
		if (waiting) begin
			if (e.action == ACT_TUNNEL) return make(V_BUSY, 0, 0, 0, 0);
			if (e.action == ACT_FRAME && e.ftype == data_type && e.port == GW_PORT &&
					e.ctrl == CTRL_REPLY && e.w0 == wait_ip && e.w1 == local_ip) begin
				learn(wait_ip, {e.snet, e.sstn});
				waiting = 1'b0;
				tries = 0;
				return make(V_SEND, e.snet, e.sstn, 0, 0);
			end
			if (e.action == ACT_FRAME || e.action == ACT_TIMEOUT) begin
				if (tries < MAX_ATTEMPTS) begin
					tries++;
					return make(V_QUERY, QUERY_ADDR, QUERY_ADDR, local_ip, wait_ip);
				end
				waiting = 1'b0;
				tries = 0;
				return make(V_DROP, 0, 0, 0, 0);
			end
			return make(V_IGNORE, 0, 0, 0, 0);
		end
		if (e.action == ACT_FRAME) begin
			if (e.ftype == bcast_type && e.port == GW_PORT && e.ctrl == CTRL_REQUEST) begin
				if (e.w1 == local_ip) begin
					learn(e.w0, {e.snet, e.sstn});
					return make(V_REPLY, e.snet, e.sstn, e.w1, e.w0);
				end
			end else if (e.ftype == data_type && e.port == GW_PORT && e.ctrl == CTRL_DATA)
				return make(V_TUNNEL, 0, 0, 0, 0);
		end else if (e.action == ACT_TUNNEL) begin
			p = (prefix_len > 32) ? 32 : prefix_len;
			mask = (p == 0) ? 32'h0 : (32'hffff_ffff << (32 - p));
			if ((e.rip & mask) != (local_ip & mask)) return make(V_DROP, 0, 0, 0, 0);
			i = lookup(e.rip);
			if (i >= 0) return make(V_SEND, cache_stn[i][15:8], cache_stn[i][7:0], 0, 0);
			waiting = 1'b1;
			wait_ip = e.rip;
			tries = 1;
			return make(V_QUERY, QUERY_ADDR, QUERY_ADDR, local_ip, e.rip);
		end
		return make(V_IGNORE, 0, 0, 0, 0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gw_event_t   e;
		gw_verdict_t got, exp_v;
		if (!arst_n) begin
			local_ip = 0; prefix_len = 24; bcast_type = 1; data_type = 2;
			for (int i = 0; i < CACHE_DEPTH; i++) cache_ok[i] = 1'b0;
			repl_ptr = 0; waiting = 1'b0; wait_ip = 0; tries = 0;
			verdict_q.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				case (cfg.index)
					CFG_LOCAL_IP:   local_ip   = cfg.data;
					CFG_PREFIX_LEN: prefix_len = cfg.data[5:0];
					CFG_BCAST_TYPE: bcast_type = cfg.data[7:0];
					CFG_DATA_TYPE:  data_type  = cfg.data[7:0];
					default: ;
				endcase
			if (rsp.valid && rsp.ready) begin
				got = make(rsp.verdict, rsp.target_net, rsp.target_station,
					rsp.out_first_ip, rsp.out_second_ip);
				if (verdict_q.size() == 0) begin
					$error("verdict beat with nothing expected: verdict %0d", got.verdict);
					errors++;
				end else begin
					exp_v = verdict_q.pop_front();
					if (got.verdict !== exp_v.verdict) begin
						$error("verdict: expected %0d, got %0d", exp_v.verdict, got.verdict);
						errors++;
					end
					if (got.net !== exp_v.net) begin
						$error("target_net: expected %0h, got %0h", exp_v.net, got.net);
						errors++;
					end
					if (got.stn !== exp_v.stn) begin
						$error("target_station: expected %0h, got %0h", exp_v.stn, got.stn);
						errors++;
					end
					if (got.first_ip !== exp_v.first_ip) begin
						$error("out_first_ip: expected %0h, got %0h", exp_v.first_ip,
							got.first_ip);
						errors++;
					end
					if (got.second_ip !== exp_v.second_ip) begin
						$error("out_second_ip: expected %0h, got %0h", exp_v.second_ip,
							got.second_ip);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				e.action = req.action; e.ftype = req.frame_type; e.port = req.frame_port;
				e.ctrl = req.frame_ctrl; e.snet = req.source_net;
				e.sstn = req.source_station; e.w0 = req.first_word_ip;
				e.w1 = req.second_word_ip; e.rip = req.route_ip;
				verdict_q.push_back(predict_verdict(e));
			end
		end
	end
endmodule

// ===== tb/tb_arp_cache_gateway_engine_unit.sv =====
// Testbench top: drives events and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_arp_cache_gateway_engine_unit;
	import acge_pkg::*;
	import gw_tb_types::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending_verdicts;
	logic stall_long;       // receiver held off for a long stretch
	logic [31:0] tb_local;  // mirror of local_ip as last written
	logic [31:0] asker_ips [8];

	gw_in_if  req();
	gw_out_if rsp();
	gw_cfg_if cfg();

	arp_cache_gateway_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	gw_verdict_checker i_checker (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending_verdicts(pending_verdicts)
	);

	// 8 ns clock.
	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// Receiver: stall on its own pattern; long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_long) begin
			rsp.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 3))
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 3) != 0);
				2: rsp.ready <= $urandom_range(0, 1);
				default: rsp.ready <= 1'b1;
			endcase
		end
	end

	// Send one register write, wait for its beat, then drop valid.
	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_LOCAL_IP) tb_local = value;
		@(posedge clk);
	endtask

	// Offer one event and hold it until accepted.
	task automatic send_event(gw_event_t e);
		req.valid <= 1'b1;
		req.action <= e.action; req.frame_type <= e.ftype; req.frame_port <= e.port;
		req.frame_ctrl <= e.ctrl; req.source_net <= e.snet;
		req.source_station <= e.sstn; req.first_word_ip <= e.w0;
		req.second_word_ip <= e.w1; req.route_ip <= e.rip;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic idle_gap(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Wait until every verdict has come, then let the back end settle.
	task automatic drain();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts != 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic gw_event_t ev(logic [1:0] a, logic [7:0] t, logic [7:0] p,
			logic [7:0] c, logic [7:0] n, logic [7:0] s, logic [31:0] w0,
			logic [31:0] w1, logic [31:0] r);
		gw_event_t e;
		e.action = a; e.ftype = t; e.port = p; e.ctrl = c; e.snet = n; e.sstn = s;
		e.w0 = w0; e.w1 = w1; e.rip = r;
		return e;
	endfunction

	// Random event: mostly well-formed with random content, some noise.
	function automatic gw_event_t random_event(logic [7:0] bt, logic [7:0] dt,
			logic [5:0] pfx);
		gw_event_t e;
		logic [31:0] host;
		e = ev($urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		host = (pfx >= 32) ? 32'h0 : ($urandom & ~(32'hffff_ffff << (32 - pfx)));
		case ($urandom_range(0, 9))
			0, 1: begin  // resolution request for us
				e.action = ACT_FRAME; e.ftype = bt; e.port = GW_PORT;
				e.ctrl = CTRL_REQUEST; e.w1 = tb_local;
				e.w0 = asker_ips[$urandom_range(0, 7)];
				if ($urandom_range(0, 3) == 0) e.w0 = $urandom;
			end
			2, 3: begin  // tunnel packet, mostly inside the subnet
				e.action = ACT_TUNNEL;
				e.rip = ($urandom_range(0, 1)) ? asker_ips[$urandom_range(0, 7)] :
					((tb_local & ~((pfx >= 32) ? 32'h0 :
					~(32'hffff_ffff << (32 - pfx)))) | host);
				if ($urandom_range(0, 5) == 0) e.rip = $urandom;
			end
			4: begin  // reply to a pending query (may or may not match)
				e.action = ACT_FRAME; e.ftype = dt; e.port = GW_PORT;
				e.ctrl = CTRL_REPLY; e.w1 = tb_local;
				e.w0 = asker_ips[$urandom_range(0, 7)];
			end
			5: begin  // data frame
				e.action = ACT_FRAME; e.ftype = dt; e.port = GW_PORT; e.ctrl = CTRL_DATA;
			end
			6: e.action = ACT_TIMEOUT;
			7: begin  // nearly a request, one header field off
				e.action = ACT_FRAME; e.ftype = bt; e.port = GW_PORT;
				e.ctrl = CTRL_REQUEST; e.w1 = $urandom;
			end
			default: ;
		endcase
		return e;
	endfunction

	// Run n random events in bursts; pfx names the current prefix length.
	task automatic random_phase(int n, logic [7:0] bt, logic [7:0] dt, logic [5:0] pfx);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				send_event(random_event(bt, dt, pfx));
				burst--; n--;
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
		end
		drain();
	endtask

	// Every random event after the last write uses tb_local; the subnet is given by the
	// prefix passed in, matching the register written just before.
	initial begin
		logic [31:0] lip;
		stall_long = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0; req.action = '0; req.frame_type = '0; req.frame_port = '0;
		req.frame_ctrl = '0; req.source_net = '0; req.source_station = '0;
		req.first_word_ip = '0; req.second_word_ip = '0; req.route_ip = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		tb_local = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, then a set address.
		lip = 32'h0a00_0001;
		write_reg(CFG_LOCAL_IP, lip);
		for (int i = 0; i < 8; i++) asker_ips[i] = {lip[31:8], 8'(i + 2)};
		send_event(ev(ACT_FRAME, 8'd1, GW_PORT, CTRL_REQUEST, 8'hff, 8'h00,
			asker_ips[0], lip, 0));                                   // reply, learn
		send_event(ev(ACT_TUNNEL, 0, 0, 0, 0, 0, 0, 0, asker_ips[0])); // hit
		send_event(ev(ACT_FRAME, 8'd2, GW_PORT, CTRL_DATA, 0, 0, 0, 0, 0)); // tunnel
		send_event(ev(ACT_TUNNEL, 0, 0, 0, 0, 0, 0, 0, 32'hc0a8_0001)); // off-subnet
		send_event(ev(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0));           // ignored
		send_event(ev(2'd3, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, '1, '1, '1)); // ignored
		send_event(ev(ACT_FRAME, 8'd1, GW_PORT, CTRL_REQUEST, 1, 2, 3, 4, 0)); // not us
		send_event(ev(ACT_FRAME, 8'd2, GW_PORT, CTRL_REPLY, 1, 2, 3, lip, 0)); // stray
		send_event(ev(ACT_TUNNEL, 0, 0, 0, 0, 0, 0, 0, asker_ips[1])); // miss, query
		send_event(ev(ACT_TUNNEL, 0, 0, 0, 0, 0, 0, 0, asker_ips[2])); // busy
		send_event(ev(ACT_FRAME, 8'd2, GW_PORT, CTRL_REPLY, 8'h12, 8'h34,
			asker_ips[1], lip, 0));                                   // matching reply
		send_event(ev(ACT_TUNNEL, 0, 0, 0, 0, 0, 0, 0, asker_ips[3])); // miss again
		for (int i = 0; i < 5; i++)                                   // exhaust, drop
			send_event(ev(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0));
		send_event(ev(ACT_FRAME, 0, 0, 0, 0, 0, '0, '0, '0));
		// Fill past the cache depth to force round-robin replacement.
		for (int i = 0; i < 20; i++)
			send_event(ev(ACT_FRAME, 8'd1, GW_PORT, CTRL_REQUEST, 8'(i), 8'(i),
				32'h0a00_1000 + i, lip, 0));
		drain();

		// Pressure: hold the receiver off while events keep coming.
		stall_long = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				stall_long = 1'b0;
			end
			begin
				for (int i = 0; i < 12; i++) send_event(random_event(8'd1, 8'd2, 6'd24));
				req.valid <= 1'b0;
				@(posedge clk);
			end
		join
		drain();

		random_phase(100, 8'd1, 8'd2, 6'd24);

		// Extremes: prefix 0 and prefix beyond 32, type codes at 0 and 255.
		write_reg(CFG_PREFIX_LEN, 32'd0);
		write_reg(CFG_BCAST_TYPE, 32'd255);
		write_reg(CFG_DATA_TYPE, 32'd0);
		random_phase(80, 8'd255, 8'd0, 6'd0);

		lip = 32'hffff_fffe;
		write_reg(CFG_LOCAL_IP, lip);
		write_reg(CFG_PREFIX_LEN, 32'd63);
		for (int i = 0; i < 8; i++) asker_ips[i] = (i < 2) ? lip : $urandom;
		random_phase(60, 8'd255, 8'd0, 6'd32);

		lip = 32'h0000_0000;
		write_reg(CFG_LOCAL_IP, lip);
		write_reg(CFG_PREFIX_LEN, 32'd28);
		write_reg(CFG_BCAST_TYPE, 32'd0);
		write_reg(CFG_DATA_TYPE, 32'd255);
		for (int i = 0; i < 8; i++) asker_ips[i] = 32'(i + 1);
		random_phase(80, 8'd0, 8'd255, 6'd28);

		lip = 32'hac10_2001;
		write_reg(CFG_LOCAL_IP, lip);
		write_reg(CFG_PREFIX_LEN, 32'd16);
		write_reg(CFG_BCAST_TYPE, 32'h5a);
		write_reg(CFG_DATA_TYPE, 32'ha5);
		for (int i = 0; i < 8; i++) asker_ips[i] = {lip[31:16], 16'($urandom)};
		random_phase(80, 8'h5a, 8'ha5, 6'd16);

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard limit on the run.
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
